[hdl/psq_pkg.sv]
// Package for the 6x6 Polybius square codec: field widths, codes, the job record
// passed from the front end to the back end, and the square lookup functions.
// No dependencies; used by every module of the codec.
package psq_pkg;

   // Field widths.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CELL_W   = 6;
   localparam int unsigned POS_W    = 3;

   // Job queue between front end and back end.
   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);
   localparam logic [FIFO_AW-1:0] FIFO_LAST_PTR   = FIFO_AW'(FIFO_DEPTH - 1);
   localparam logic [FIFO_CW-1:0] FIFO_FULL_COUNT = FIFO_CW'(FIFO_DEPTH);

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_CHAR  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_LABEL = 2'd2;

   // Character codes.
   localparam logic [BYTE_W-1:0] CHAR_LF      = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_CR      = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [BYTE_W-1:0] CHAR_ONE     = 8'd49;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'd57;
   localparam logic [BYTE_W-1:0] CHAR_UP_A    = 8'd65;
   localparam logic [BYTE_W-1:0] CHAR_UP_Z    = 8'd90;
   localparam logic [BYTE_W-1:0] CHAR_LO_A    = 8'd97;
   localparam logic [BYTE_W-1:0] CHAR_LO_Z    = 8'd122;
   localparam logic [BYTE_W-1:0] CHAR_ERR     = 8'd63;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'd32;
   // Digits occupy cells 27..35, so cell = byte - ('1' - 27).
   localparam logic [BYTE_W-1:0] DIGIT_OFFSET = 8'd22;

   // Square geometry.
   localparam logic [CELL_W-1:0] SIDE        = 6'd6;
   localparam logic [CELL_W-1:0] CELL_SPACE  = 6'd26;
   localparam logic [CELL_W-1:0] CELL_NONE   = 6'd63;
   localparam logic [POS_W-1:0]  POS_NONE    = 3'd7;
   localparam logic [POS_W-1:0]  POS_LAST    = 3'd5;
   // Marker in the held row when the held byte was not a square character.
   localparam logic [POS_W-1:0]  ROW_NOT_CHAR = 3'd1;

   // One unit of back-end work: one or two results.
   typedef struct packed {
      logic                pair;
      logic [BYTE_W-1:0]   first;
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   second;
   } job_type;

   // Fold lowercase letters to uppercase.
   function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] b);
      if (b >= CHAR_LO_A && b <= CHAR_LO_Z) begin
         return b - CASE_OFFSET;
      end
      return b;
   endfunction

   // Square cell of a folded byte, or CELL_NONE.
   function automatic logic [CELL_W-1:0] cell_of(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] d;
      d = 8'd0;
      if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
         d = b - CHAR_UP_A;
         return d[CELL_W-1:0];
      end
      if (b == CHAR_SPACE) begin
         return CELL_SPACE;
      end
      if (b >= CHAR_ONE && b <= CHAR_NINE) begin
         d = b - DIGIT_OFFSET;
         return d[CELL_W-1:0];
      end
      return CELL_NONE;
   endfunction

   // Row of a valid cell (cell / 6) by a compare chain.
   function automatic logic [POS_W-1:0] row_of_cell(input logic [CELL_W-1:0] idx);
      if (idx < 6'd6)  return 3'd0;
      if (idx < 6'd12) return 3'd1;
      if (idx < 6'd18) return 3'd2;
      if (idx < 6'd24) return 3'd3;
      if (idx < 6'd30) return 3'd4;
      return 3'd5;
   endfunction

   // First cell of a row (row * 6).
   function automatic logic [CELL_W-1:0] row_base(input logic [POS_W-1:0] row);
      logic [CELL_W-1:0] r;
      r = {{(CELL_W-POS_W){1'b0}}, row};
      return (r << 2) + (r << 1);
   endfunction

   // Plain character of a valid cell.
   function automatic logic [BYTE_W-1:0] char_of(input logic [CELL_W-1:0] idx);
      logic [BYTE_W-1:0] c;
      c = {{(BYTE_W-CELL_W){1'b0}}, idx};
      if (idx < CELL_SPACE) begin
         return c + CHAR_UP_A;
      end
      if (idx == CELL_SPACE) begin
         return CHAR_SPACE;
      end
      return c + DIGIT_OFFSET;
   endfunction

   // Row labels N,O,R,M,A,L.
   function automatic logic [BYTE_W-1:0] row_label(input logic [POS_W-1:0] row);
      case (row)
         3'd0:    return 8'd78;
         3'd1:    return 8'd79;
         3'd2:    return 8'd82;
         3'd3:    return 8'd77;
         3'd4:    return 8'd65;
         3'd5:    return 8'd76;
         default: return CHAR_ERR;
      endcase
   endfunction

   // Column labels X,I,F,R,A,T.
   function automatic logic [BYTE_W-1:0] col_label(input logic [POS_W-1:0] col);
      case (col)
         3'd0:    return 8'd88;
         3'd1:    return 8'd73;
         3'd2:    return 8'd70;
         3'd3:    return 8'd82;
         3'd4:    return 8'd65;
         3'd5:    return 8'd84;
         default: return CHAR_ERR;
      endcase
   endfunction

   // Row position of a folded label byte, or POS_NONE.
   function automatic logic [POS_W-1:0] row_pos(input logic [BYTE_W-1:0] b);
      case (b)
         8'd78:   return 3'd0;
         8'd79:   return 3'd1;
         8'd82:   return 3'd2;
         8'd77:   return 3'd3;
         8'd65:   return 3'd4;
         8'd76:   return 3'd5;
         default: return POS_NONE;
      endcase
   endfunction

   // Column position of a folded label byte, or POS_NONE.
   function automatic logic [POS_W-1:0] col_pos(input logic [BYTE_W-1:0] b);
      case (b)
         8'd88:   return 3'd0;
         8'd73:   return 3'd1;
         8'd70:   return 3'd2;
         8'd82:   return 3'd3;
         8'd65:   return 3'd4;
         8'd84:   return 3'd5;
         default: return POS_NONE;
      endcase
   endfunction

endpackage

[hdl/psq_front.sv]
// Front end of the Polybius square codec: accepts input bytes, tracks the
// decrypt pairing and turns each byte into a job for the back end.
// Depends on psq_pkg.
module psq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          decrypt_mode,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [psq_pkg::BYTE_W-1:0]    req_tdata,
   input  logic                          job_full,
   output logic                          job_push,
   output psq_pkg::job_type              job_data
);

   logic                         pend_valid_ff, pend_valid_in;
   logic [psq_pkg::POS_W-1:0]    pend_row_ff, pend_row_in;
   logic                         pend_bad_ff, pend_bad_in;

   logic                         accept;
   logic                         line_end;
   logic [psq_pkg::BYTE_W-1:0]   folded;
   logic [psq_pkg::CELL_W-1:0]   square_idx;
   logic                         cell_ok;
   logic [psq_pkg::POS_W-1:0]    enc_row;
   logic [psq_pkg::POS_W-1:0]    enc_col;
   logic [psq_pkg::CELL_W-1:0]   enc_col_wide;
   logic [psq_pkg::POS_W-1:0]    lab_row;
   logic [psq_pkg::POS_W-1:0]    lab_col;
   logic                         first_not_char;
   logic [psq_pkg::CELL_W-1:0]   dec_cell;
   logic                         emits;

   // A transaction is taken whenever the job queue has room.
   assign req_tready = !job_full;
   assign accept     = req_tvalid && !job_full;

   // Classify the byte.
   assign line_end     = (req_tdata == psq_pkg::CHAR_LF) || (req_tdata == psq_pkg::CHAR_CR);
   assign folded       = psq_pkg::fold_upper(req_tdata);
   assign square_idx   = psq_pkg::cell_of(folded);
   assign cell_ok      = (square_idx != psq_pkg::CELL_NONE);
   assign enc_row      = psq_pkg::row_of_cell(square_idx);
   assign enc_col_wide = square_idx - psq_pkg::row_base(enc_row);
   assign enc_col      = enc_col_wide[psq_pkg::POS_W-1:0];
   assign lab_row      = psq_pkg::row_pos(folded);
   assign lab_col      = psq_pkg::col_pos(folded);
   assign first_not_char = pend_bad_ff && (pend_row_ff == psq_pkg::ROW_NOT_CHAR);
   assign dec_cell     = psq_pkg::row_base(pend_row_ff) +
                         {{(psq_pkg::CELL_W-psq_pkg::POS_W){1'b0}}, lab_col};

   // Build the job and the next pairing state.
   always_comb begin
      emits         = 1'b0;
      job_data      = '0;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      pend_bad_in   = pend_bad_ff;
      if (line_end) begin
         pend_valid_in = 1'b0;
         pend_row_in   = '0;
         pend_bad_in   = 1'b0;
      end else if (!decrypt_mode) begin
         pend_valid_in = 1'b0;
         pend_row_in   = '0;
         pend_bad_in   = 1'b0;
         emits         = 1'b1;
         if (cell_ok) begin
            job_data.pair   = 1'b1;
            job_data.first  = psq_pkg::row_label(enc_row);
            job_data.status = psq_pkg::ST_OK;
            job_data.second = psq_pkg::col_label(enc_col);
         end else begin
            job_data.first  = psq_pkg::CHAR_ERR;
            job_data.status = psq_pkg::ST_BAD_CHAR;
         end
      end else if (!pend_valid_ff) begin
         pend_valid_in = 1'b1;
         if (!cell_ok) begin
            pend_bad_in = 1'b1;
            pend_row_in = psq_pkg::ROW_NOT_CHAR;
         end else if (lab_row == psq_pkg::POS_NONE) begin
            pend_bad_in = 1'b1;
            pend_row_in = '0;
         end else begin
            pend_bad_in = 1'b0;
            pend_row_in = lab_row;
         end
      end else begin
         emits         = 1'b1;
         pend_valid_in = 1'b0;
         pend_row_in   = '0;
         pend_bad_in   = 1'b0;
         if (first_not_char || !cell_ok) begin
            job_data.first  = psq_pkg::CHAR_ERR;
            job_data.status = psq_pkg::ST_BAD_CHAR;
         end else if (pend_bad_ff || lab_col == psq_pkg::POS_NONE ||
                      pend_row_ff > psq_pkg::POS_LAST) begin
            job_data.first  = psq_pkg::CHAR_ERR;
            job_data.status = psq_pkg::ST_BAD_LABEL;
         end else begin
            job_data.first  = psq_pkg::char_of(dec_cell);
            job_data.status = psq_pkg::ST_OK;
         end
      end
   end

   assign job_push = accept && emits;

   // Pairing state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_row_ff   <= '0;
         pend_bad_ff   <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= pend_valid_in;
         pend_row_ff   <= pend_row_in;
         pend_bad_ff   <= pend_bad_in;
      end
   end

endmodule

[hdl/psq_fifo.sv]
// Short job queue between the codec front end and back end.
// Depends on psq_pkg for the job record and the queue depth.
module psq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  psq_pkg::job_type  push_data,
   output logic              full,
   input  logic              pop,
   output psq_pkg::job_type  pop_data,
   output logic              empty
);

   psq_pkg::job_type                entry_ff [psq_pkg::FIFO_DEPTH];
   logic [psq_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [psq_pkg::FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [psq_pkg::FIFO_CW-1:0]     count_ff, count_in;

   assign full     = (count_ff == psq_pkg::FIFO_FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == psq_pkg::FIFO_LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == psq_pkg::FIFO_LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/psq_back.sv]
// Back end of the Polybius square codec: takes jobs from the queue and
// delivers one or two results through a registered output stage.
// Depends on psq_pkg.
module psq_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   input  psq_pkg::job_type              job_data,
   output logic                          job_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [psq_pkg::BYTE_W-1:0]    rsp_tdata,
   output logic [psq_pkg::STATUS_W-1:0]  rsp_tuser,
   output logic                          rsp_tlast
);

   logic                          out_valid_ff, out_valid_in;
   logic [psq_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic [psq_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic                          out_last_ff, out_last_in;
   logic                          hold_valid_ff, hold_valid_in;
   logic [psq_pkg::BYTE_W-1:0]    hold_byte_ff, hold_byte_in;
   logic                          out_free;

   // The output register can load when empty or being taken this cycle.
   assign out_free = !out_valid_ff || rsp_tready;
   assign job_pop  = out_free && !hold_valid_ff && !job_empty;

   // Pick the next result: the held column label first, then a new job.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      if (out_free) begin
         if (hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = hold_byte_ff;
            out_status_in = psq_pkg::ST_OK;
            out_last_in   = 1'b1;
            hold_valid_in = 1'b0;
         end else if (!job_empty) begin
            out_valid_in  = 1'b1;
            out_byte_in   = job_data.first;
            out_status_in = job_data.status;
            out_last_in   = !job_data.pair;
            hold_valid_in = job_data.pair;
            hold_byte_in  = job_data.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
      hold_byte_ff  <= hold_byte_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[hdl/polybius_square_codec_top.sv]
// Polybius square codec top level: mode register, front end, job queue and back end.
// Depends on psq_pkg, psq_front, psq_fifo and psq_back.
//
// Encrypts bytes into row/column label pairs of a fixed 6x6 square (A-Z, space,
// 1-9; rows N,O,R,M,A,L; columns X,I,F,R,A,T) or, with csr_wdata[0] set, decrypts
// label pairs back to characters; lowercase is folded to uppercase and LF or CR
// ends a message. A valid byte in encrypt mode yields two results, which the single
// output register sends one after the other, so it sets the input pace in that mode;
// decrypt mode and line ends take one input per cycle while the job queue has room.
// A result passes through the job queue and then the output register before it is
// presented on the output. A two-entry job queue lets input keep flowing while the
// output is stalled. Errors give '?' with status 1 (not a square character) or 2
// (unknown label). Write csr_we only while the block is idle.
module polybius_square_codec_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_wdata,   // [0] decrypt_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_of_run
);

   logic              decrypt_mode_ff;
   logic              job_push;
   logic              job_pop;
   logic              job_full;
   logic              job_empty;
   psq_pkg::job_type  push_job;
   psq_pkg::job_type  pop_job;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
      end else if (csr_we) begin
         decrypt_mode_ff <= csr_wdata[0];
      end
   end

   psq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .decrypt_mode (decrypt_mode_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .job_full     (job_full),
      .job_push     (job_push),
      .job_data     (push_job)
   );

   psq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (pop_job),
      .empty     (job_empty)
   );

   psq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_data   (pop_job),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // An error result always carries '?' and ends its run.
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != psq_pkg::ST_OK) |->
         (rsp_tdata == psq_pkg::CHAR_ERR && rsp_tlast))
      else $error("error result without '?' or tlast");

   // The first half of a label pair is always a successful result.
   a_first_half_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == psq_pkg::ST_OK))
      else $error("non-final result with error status");

   // A taken first half is followed at once by its final half.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("column label did not follow row label");

   // Nothing enters the queue while it is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      job_full |-> !job_push)
      else $error("job pushed into a full queue");
`endif

endmodule

[verif/polybius_square_codec_top_tb.sv]
// Self-checking testbench for polybius_square_codec_top: directed and random byte streams
// in both cipher modes, with a built-in mirror of the square cipher that checks every result.
// Depends on psq_pkg and the RTL of the codec; reads no files.
`timescale 1ns / 100ps

module polybius_square_codec_top_tb;

   localparam int  SETTLE_CYCLES = 8;
   localparam int  LONG_HOLD     = 120;
   localparam int  RANDOM_PHASES = 8;
   localparam int  PHASE_ITEMS   = 116;
   localparam int  REPORT_LIMIT  = 10;
   localparam bit  MODE_ENCRYPT  = 1'b0;
   localparam bit  MODE_DECRYPT  = 1'b1;

   // Row and column labels of the square, in order.
   localparam logic [7:0] ROW_TAG [6] = '{"N", "O", "R", "M", "A", "L"};
   localparam logic [7:0] COL_TAG [6] = '{"X", "I", "F", "R", "A", "T"};

   // One result transaction: plain or label byte, status, end of run.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] status;
      logic       last;
   } codec_out_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [0:0] csr_wdata;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   bit tx_idle_on;
   bit rx_stall_on;
   bit hold_request;
   int phase_sent;
   int mode_writes;

   // Cell 0..35 of an uppercase byte, or -1 when it is not in the square.
   function automatic int square_cell(input logic [7:0] b);
      if (b >= "A" && b <= "Z") return int'(b) - int'("A");
      if (b == " ") return 26;
      if (b >= "1" && b <= "9") return 27 + int'(b) - int'("1");
      return -1;
   endfunction

   function automatic logic [7:0] square_char(input int idx);
      if (idx < 26) return 8'(int'("A") + idx);
      if (idx == 26) return " ";
      return 8'(int'("1") + idx - 27);
   endfunction

   // Position of a byte among the row or column labels, or -1.
   function automatic int tag_pos(input bit rows, input logic [7:0] b);
      for (int i = 0; i < 6; i++) begin
         if ((rows ? ROW_TAG[i] : COL_TAG[i]) == b) return i;
      end
      return -1;
   endfunction

   // Mirror of the codec: mode, held half pair and the results still awaited.
   class square_codec_mirror_type;
      bit            decrypt_on;
      bit            held_valid;
      bit [2:0]      held_row;
      bit            held_bad;
      codec_out_type awaited_out[$];
      int            bytes_taken;
      int            results_seen;
      int            mismatches;
      int            status_seen[3];

      function new();
         decrypt_on = MODE_ENCRYPT;
         drop_pair();
      endfunction

      function void drop_pair();
         held_valid = 1'b0;
         held_row   = 3'd0;
         held_bad   = 1'b0;
      endfunction

      function void write_mode(input bit m);
         decrypt_on = m;
      endfunction

      function void await_out(input logic [7:0] d, input logic [1:0] s, input logic l);
         awaited_out.push_back('{data: d, status: s, last: l});
      endfunction

      // Work out the results caused by one accepted input transaction.
      function void take_byte(input logic [7:0] raw);
         logic [7:0] b;
         int         idx;
         int         pos;
         bytes_taken++;
         if (raw == psq_pkg::CHAR_LF || raw == psq_pkg::CHAR_CR) begin
            drop_pair();
            return;
         end
         b   = (raw >= "a" && raw <= "z") ? raw - 8'd32 : raw;
         idx = square_cell(b);

         // Encryption always forgets a half pair left over from decryption.
         if (decrypt_on == MODE_ENCRYPT) begin
            drop_pair();
            if (idx < 0) begin
               await_out(psq_pkg::CHAR_ERR, psq_pkg::ST_BAD_CHAR, 1'b1);
            end else begin
               await_out(ROW_TAG[idx / 6], psq_pkg::ST_OK, 1'b0);
               await_out(COL_TAG[idx % 6], psq_pkg::ST_OK, 1'b1);
            end
            return;
         end

         // First byte of a pair is only held, with a note of what was wrong with it.
         if (!held_valid) begin
            pos        = tag_pos(1'b1, b);
            held_valid = 1'b1;
            if (idx < 0) begin
               held_bad = 1'b1;
               held_row = 3'd1;
            end else if (pos < 0) begin
               held_bad = 1'b1;
               held_row = 3'd0;
            end else begin
               held_bad = 1'b0;
               held_row = 3'(pos);
            end
            return;
         end

         // Second byte completes the pair; a bad character outranks a bad label.
         pos = tag_pos(1'b0, b);
         if ((held_bad && held_row == 3'd1) || idx < 0) begin
            await_out(psq_pkg::CHAR_ERR, psq_pkg::ST_BAD_CHAR, 1'b1);
         end else if (held_bad || pos < 0 || held_row > 3'd5) begin
            await_out(psq_pkg::CHAR_ERR, psq_pkg::ST_BAD_LABEL, 1'b1);
         end else begin
            await_out(square_char(int'(held_row) * 6 + pos), psq_pkg::ST_OK, 1'b1);
         end
         drop_pair();
      endfunction

      // Compare one result transaction with the oldest awaited one.
      function void match_result(input codec_out_type got);
         codec_out_type want;
         if (awaited_out.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: result with none awaited: data %h status %0d last %b",
                        $realtime, got.data, got.status, got.last);
            end
            return;
         end
         want = awaited_out.pop_front();
         results_seen++;
         if (got.status < 3) status_seen[got.status]++;
         if (got.data !== want.data || got.status !== want.status ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: result mismatch: expected data %h status %0d last %b,",
                        $realtime, want.data, want.status, want.last);
               $display("   got data %h status %0d last %b",
                        got.data, got.status, got.last);
            end
         end
      endfunction

      // Results that never arrived count as failures too.
      function void close_out();
         if (awaited_out.size() != 0) begin
            mismatches++;
            $display("%0d awaited results never arrived", awaited_out.size());
         end
      endfunction
   endclass

   square_codec_mirror_type mirror = new();

   polybius_square_codec_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock with a 2 ns period.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Gap lengths: mostly short, now and then long.
   function automatic int short_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return $urandom_range(1, 2);
      if (p < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic int tx_gap();
      if (!tx_idle_on || $urandom_range(0, 99) < 55) return 0;
      return short_gap();
   endfunction

   function automatic logic [7:0] mixed_case(input logic [7:0] ch);
      if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) return ch + 8'd32;
      return ch;
   endfunction

   function automatic logic [7:0] any_square_char();
      return mixed_case(square_char($urandom_range(0, 35)));
   endfunction

   function automatic logic [7:0] line_end();
      return ($urandom_range(0, 1) == 1) ? psq_pkg::CHAR_LF : psq_pkg::CHAR_CR;
   endfunction

   // Offer one byte, wait for its transaction, then maybe idle. Starts and ends at a falling edge.
   task automatic push_byte(input logic [7:0] b);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      mirror.take_byte(b);
      @(negedge clock);
      gap = tx_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stop offering and wait until every awaited result is in and the block has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (mirror.awaited_out.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input bit m);
      csr_wdata <= m;
      csr_we    <= 1'b1;
      @(posedge clock);
      mirror.write_mode(m);
      mode_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // One random step of encryption traffic.
   task automatic encrypt_step();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         push_byte(any_square_char());
         phase_sent++;
      end else if (kind < 88) begin
         push_byte(8'($urandom_range(0, 255)));
         phase_sent++;
      end else if (kind < 94) begin
         push_byte(line_end());
      end else begin
         push_byte(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
         phase_sent++;
      end
   endtask

   // One random step of decryption traffic: mostly well-formed label pairs.
   task automatic decrypt_step();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         push_byte(mixed_case(ROW_TAG[$urandom_range(0, 5)]));
         push_byte(mixed_case(COL_TAG[$urandom_range(0, 5)]));
         phase_sent += 2;
      end else if (kind < 78) begin
         push_byte(mixed_case(ROW_TAG[$urandom_range(0, 5)]));
         push_byte(8'($urandom_range(0, 255)));
         phase_sent += 2;
      end else if (kind < 84) begin
         push_byte(8'($urandom_range(0, 255)));
         push_byte(mixed_case(COL_TAG[$urandom_range(0, 5)]));
         phase_sent += 2;
      end else if (kind < 90) begin
         push_byte(8'($urandom_range(0, 255)));
         phase_sent++;
      end else if (kind < 95) begin
         push_byte(line_end());
      end else begin
         push_byte(any_square_char());
         push_byte(any_square_char());
         phase_sent += 2;
      end
   endtask

   // Result side: random stalls, and one long hold-off whenever the sender asks for it.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            gap = short_gap();
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Check every result transaction at the edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         mirror.match_result({rsp_tdata, rsp_tuser, rsp_tlast});
      end
   end

   // Stimulus: directed cases, then random phases alternating the mode.
   initial begin
      bit paused;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      tx_idle_on   = 1'b0;
      rx_stall_on  = 1'b0;
      hold_request = 1'b0;
      paused       = 1'b0;
      mode_writes  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Encryption: letters of both cases, space, a digit, bytes outside the square, line end.
      set_mode(MODE_ENCRYPT);
      push_byte("A");
      push_byte("z");
      push_byte(" ");
      push_byte("9");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte("[");
      push_byte(psq_pkg::CHAR_LF);
      wait_drained();

      // Decryption: good pairs, bad characters, unknown labels, a pair broken by a line end.
      set_mode(MODE_DECRYPT);
      push_byte("N");
      push_byte("X");
      push_byte("l");
      push_byte("t");
      push_byte("#");
      push_byte("X");
      push_byte("B");
      push_byte("X");
      push_byte("N");
      push_byte("b");
      push_byte("N");
      push_byte(psq_pkg::CHAR_CR);
      push_byte("O");
      push_byte("X");

      // A mode write leaves a held half pair alone; encryption then drops it.
      push_byte("N");
      wait_drained();
      set_mode(MODE_DECRYPT);
      push_byte("A");
      push_byte("M");
      wait_drained();
      set_mode(MODE_ENCRYPT);
      push_byte("Z");

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         set_mode(p[0] ? MODE_DECRYPT : MODE_ENCRYPT);
         tx_idle_on  = (p % 3 != 0) && p != 1;
         rx_stall_on = (p % 4 != 0);
         if (p == 1 || p == 6) hold_request = 1'b1;
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            if (p[0]) decrypt_step();
            else encrypt_step();
            // Once, pause the sender mid-phase until all results are in.
            if (p == 3 && !paused && phase_sent >= PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
         end
      end

      wait_drained();
      mirror.close_out();
      $display("Ran %0d input and %0d result transactions across %0d mode writes.",
               mirror.bytes_taken, mirror.results_seen, mode_writes);
      $display("Results ok %0d, bad character %0d, unknown label %0d; mismatches %0d.",
               mirror.status_seen[0], mirror.status_seen[1], mirror.status_seen[2],
               mirror.mismatches);
      if (mirror.mismatches == 0) begin
         $display("polybius_square_codec_top test passed");
      end else begin
         $display("polybius_square_codec_top test failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #1_000_000;
      $display("polybius_square_codec_top test failed");
      $finish;
   end

endmodule
